### rtl/yuvrgb_pkg.sv
`default_nettype none

package yuvrgb_pkg;

   // fraction bits of the precise-path coefficients
   localparam int COEF_FRAC_BITS_DEFAULT = 12;

   // reduced path: all values are integers at scale 2^-9
   localparam int BF_SHIFT = 9;
   localparam int BF_W     = 21;

   localparam logic signed [BF_W-1:0] BF_KY  = BF_W'(596);   // 1.1640625
   localparam logic signed [BF_W-1:0] BF_KRV = BF_W'(816);   // 1.59375
   localparam logic signed [BF_W-1:0] BF_KGV = BF_W'(416);   // 0.8125
   localparam logic signed [BF_W-1:0] BF_KGU = BF_W'(200);   // 0.390625
   localparam logic signed [BF_W-1:0] BF_KBU = BF_W'(1032);  // 2.015625

   // register indexes
   localparam logic [1:0] CSR_PRECISION_MODE = 2'd0;
   localparam logic [1:0] CSR_SLOT0_SELECT   = 2'd1;
   localparam logic [1:0] CSR_SLOT1_SELECT   = 2'd2;
   localparam logic [1:0] CSR_SLOT2_SELECT   = 2'd3;

   // slot select codes
   localparam logic [1:0] SEL_BLUE  = 2'd0;
   localparam logic [1:0] SEL_GREEN = 2'd1;
   localparam logic [1:0] SEL_RED   = 2'd2;

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] blue_diff;
      logic [7:0] red_diff;
   } req_type;

   typedef struct packed {
      logic [7:0] out_slot0;
      logic [7:0] out_slot1;
      logic [7:0] out_slot2;
   } rsp_type;

   // round magnitude to 8 significant bits, ties to even, sign kept
   function automatic logic signed [BF_W-1:0] bf16_round(input logic signed [BF_W-1:0] x);
      logic [BF_W-1:0] mag;
      logic [BF_W-1:0] quot;
      logic [BF_W-1:0] rem;
      logic [BF_W-1:0] half;
      logic [BF_W-1:0] res;
      int              len;
      int              sh;
      begin
         mag = x[BF_W-1] ? BF_W'(-x) : BF_W'(x);
         len = 0;
         for (int i = 0; i < BF_W; i++) begin
            if (mag[i]) begin
               len = i + 1;
            end
         end
         if (len <= 8) begin
            res = mag;
         end else begin
            sh   = len - 8;
            quot = mag >> sh;
            rem  = mag & ((BF_W'(1) << sh) - BF_W'(1));
            half = BF_W'(1) << (sh - 1);
            if ((rem > half) || ((rem == half) && quot[0])) begin
               quot = quot + BF_W'(1);
            end
            res = quot << sh;
         end
         bf16_round = x[BF_W-1] ? $signed(-res) : $signed(res);
      end
   endfunction

endpackage

`default_nettype wire

### rtl/yuvrgb_round_sat.sv
`default_nettype none

// scaled / 2^SHIFT, round to nearest even, clamp to 0..255
module yuvrgb_round_sat #(
   parameter int WIDTH = yuvrgb_pkg::BF_W,
   parameter int SHIFT = yuvrgb_pkg::BF_SHIFT
) (
   input  logic signed [WIDTH-1:0] scaled,
   output logic        [7:0]       level
);

   localparam int QW = WIDTH - SHIFT;
   localparam logic [SHIFT-1:0] HALF = SHIFT'(1) << (SHIFT - 1);

   logic [QW-1:0]    quot;
   logic [SHIFT-1:0] frac;
   logic             round_up;
   logic [QW:0]      rounded;

   assign quot     = scaled[WIDTH-1:SHIFT];
   assign frac     = scaled[SHIFT-1:0];
   assign round_up = (frac > HALF) || ((frac == HALF) && quot[0]);
   assign rounded  = {1'b0, quot} + (QW+1)'(round_up);

   always_comb begin
      if (scaled <= 0) begin
         level = 8'd0;
      end else if (rounded > (QW+1)'(255)) begin
         level = 8'hFF;
      end else begin
         level = rounded[7:0];
      end
   end

endmodule

`default_nettype wire

### rtl/yuv_to_rgb_pixel_convert.sv
`default_nettype none

// Channel  | Dir | Handshake              | Carries
// ---------+-----+------------------------+-------------------------------------
// req_     | in  | req_valid / req_stall  | req_data: luma, blue_diff, red_diff
// rsp_     | out | rsp_valid / rsp_stall  | rsp_data: out_slot0..out_slot2
// csr_     | in  | csr_valid / csr_ready  | csr_index, csr_data (ready always 1)
//
// One item per clock while rsp_stall is low. The input register loads at the
// accepting edge, then the product, sum and result registers follow in that
// order; rsp_valid rises when the result register loads.
// Synchronous active-high reset empties the pipe and loads the register
// defaults (precise mode, slots blue/green/red). Each stage holds while the
// stage after it is full and stalled; empty stages keep filling.

module yuv_to_rgb_pixel_convert #(
   parameter int COEF_FRAC_BITS = yuvrgb_pkg::COEF_FRAC_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   // item input
   input  logic                req_valid,
   output logic                req_stall,
   input  yuvrgb_pkg::req_type req_data,
   // item output
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output yuvrgb_pkg::rsp_type rsp_data,
   // register writes
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [1:0]          csr_data
);

   localparam int F  = COEF_FRAC_BITS;
   localparam int PW = F + 12;   // holds every sum of the precise path

   localparam int KY_I  = (1164 * (1 << F) + 500) / 1000;
   localparam int KRV_I = (1596 * (1 << F) + 500) / 1000;
   localparam int KGV_I = (813 * (1 << F) + 500) / 1000;
   localparam int KGU_I = (391 * (1 << F) + 500) / 1000;
   localparam int KBU_I = (2018 * (1 << F) + 500) / 1000;

   localparam logic signed [PW-1:0] KY  = PW'(KY_I);
   localparam logic signed [PW-1:0] KRV = PW'(KRV_I);
   localparam logic signed [PW-1:0] KGV = PW'(KGV_I);
   localparam logic signed [PW-1:0] KGU = PW'(KGU_I);
   localparam logic signed [PW-1:0] KBU = PW'(KBU_I);

   localparam int BW = yuvrgb_pkg::BF_W;

   // ---------------- registers ----------------
   logic       mode_ff, mode_in;
   logic [1:0] sel0_ff, sel0_in;
   logic [1:0] sel1_ff, sel1_in;
   logic [1:0] sel2_ff, sel2_in;

   // pipe control
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic s4_valid_ff, s4_valid_in;
   logic s1_free, s2_free, s3_free, s4_free;

   // stage 1: input register
   yuvrgb_pkg::req_type in_ff, in_in;

   // stage 2: scaled terms, both paths
   logic signed [PW-1:0] ys_p_ff, ys_p_in;
   logic signed [PW-1:0] rv_p_ff, rv_p_in;
   logic signed [PW-1:0] gv_p_ff, gv_p_in;
   logic signed [PW-1:0] gu_p_ff, gu_p_in;
   logic signed [PW-1:0] bu_p_ff, bu_p_in;
   logic signed [BW-1:0] ys_b_ff, ys_b_in;
   logic signed [BW-1:0] rv_b_ff, rv_b_in;
   logic signed [BW-1:0] gv_b_ff, gv_b_in;
   logic signed [BW-1:0] gu_b_ff, gu_b_in;
   logic signed [BW-1:0] bu_b_ff, bu_b_in;

   // stage 3: sums
   logic signed [PW-1:0] r_p_ff, r_p_in;
   logic signed [PW-1:0] g_p_ff, g_p_in;
   logic signed [PW-1:0] b_p_ff, b_p_in;
   logic signed [BW-1:0] r_b_ff, r_b_in;
   logic signed [BW-1:0] g1_b_ff, g1_b_in;
   logic signed [BW-1:0] gu3_b_ff, gu3_b_in;
   logic signed [BW-1:0] b_b_ff, b_b_in;

   // stage 4: result register
   yuvrgb_pkg::rsp_type rsp_ff, rsp_in;

   // ---------------- config port ----------------
   assign csr_ready = 1'b1;

   always_comb begin
      mode_in = mode_ff;
      sel0_in = sel0_ff;
      sel1_in = sel1_ff;
      sel2_in = sel2_ff;
      if (csr_valid) begin
         unique case (csr_index)
            yuvrgb_pkg::CSR_PRECISION_MODE: mode_in = csr_data[0];
            yuvrgb_pkg::CSR_SLOT0_SELECT:   sel0_in = csr_data;
            yuvrgb_pkg::CSR_SLOT1_SELECT:   sel1_in = csr_data;
            yuvrgb_pkg::CSR_SLOT2_SELECT:   sel2_in = csr_data;
            default:                        mode_in = mode_ff;
         endcase
      end
   end

   // ---------------- flow control ----------------
   // a stage can load when it is empty or its item moves on this cycle
   assign s4_free   = !s4_valid_ff || !rsp_stall;
   assign s3_free   = !s3_valid_ff || s4_free;
   assign s2_free   = !s2_valid_ff || s3_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_stall = !s1_free;

   assign s1_valid_in = req_valid;
   assign s2_valid_in = s1_valid_ff;
   assign s3_valid_in = s2_valid_ff;
   assign s4_valid_in = s3_valid_ff;

   // ---------------- stage 1 -> 2: offsets and products ----------------
   logic signed [9:0] y_s, u_s, v_s;

   assign in_in = req_data;
   assign y_s   = $signed({2'b00, in_ff.luma}) - 10'sd16;
   assign u_s   = $signed({2'b00, in_ff.blue_diff}) - 10'sd128;
   assign v_s   = $signed({2'b00, in_ff.red_diff}) - 10'sd128;

   assign ys_p_in = PW'(y_s) * KY;
   assign rv_p_in = PW'(v_s) * KRV;
   assign gv_p_in = PW'(v_s) * KGV;
   assign gu_p_in = PW'(u_s) * KGU;
   assign bu_p_in = PW'(u_s) * KBU;

   assign ys_b_in = yuvrgb_pkg::bf16_round(BW'(y_s) * yuvrgb_pkg::BF_KY);
   assign rv_b_in = BW'(v_s) * yuvrgb_pkg::BF_KRV;
   assign gv_b_in = BW'(v_s) * yuvrgb_pkg::BF_KGV;
   assign gu_b_in = BW'(u_s) * yuvrgb_pkg::BF_KGU;
   assign bu_b_in = BW'(u_s) * yuvrgb_pkg::BF_KBU;

   // ---------------- stage 2 -> 3: sums ----------------
   assign r_p_in = ys_p_ff + rv_p_ff;
   assign g_p_in = ys_p_ff - gv_p_ff - gu_p_ff;
   assign b_p_in = ys_p_ff + bu_p_ff;

   assign r_b_in   = yuvrgb_pkg::bf16_round(ys_b_ff + rv_b_ff);
   assign g1_b_in  = yuvrgb_pkg::bf16_round(ys_b_ff - gv_b_ff);
   assign gu3_b_in = gu_b_ff;
   assign b_b_in   = yuvrgb_pkg::bf16_round(ys_b_ff + bu_b_ff);

   // ---------------- stage 3 -> 4: byte rounding and slot placement ----------------
   logic signed [BW-1:0] g_b_fin;
   logic [7:0] red_p, green_p, blue_p;
   logic [7:0] red_b, green_b, blue_b;
   logic [7:0] red, green, blue;

   // green takes its second rounding here
   assign g_b_fin = yuvrgb_pkg::bf16_round(g1_b_ff - gu3_b_ff);

   yuvrgb_round_sat #(.WIDTH(PW), .SHIFT(F)) u_red_p (
      .scaled(r_p_ff), .level(red_p));
   yuvrgb_round_sat #(.WIDTH(PW), .SHIFT(F)) u_green_p (
      .scaled(g_p_ff), .level(green_p));
   yuvrgb_round_sat #(.WIDTH(PW), .SHIFT(F)) u_blue_p (
      .scaled(b_p_ff), .level(blue_p));
   yuvrgb_round_sat #(.WIDTH(BW), .SHIFT(yuvrgb_pkg::BF_SHIFT)) u_red_b (
      .scaled(r_b_ff), .level(red_b));
   yuvrgb_round_sat #(.WIDTH(BW), .SHIFT(yuvrgb_pkg::BF_SHIFT)) u_green_b (
      .scaled(g_b_fin), .level(green_b));
   yuvrgb_round_sat #(.WIDTH(BW), .SHIFT(yuvrgb_pkg::BF_SHIFT)) u_blue_b (
      .scaled(b_b_ff), .level(blue_b));

   assign red   = mode_ff ? red_b   : red_p;
   assign green = mode_ff ? green_b : green_p;
   assign blue  = mode_ff ? blue_b  : blue_p;

   // unused select code gives zero
   function automatic logic [7:0] pick(input logic [1:0] sel, input logic [7:0] b,
                                       input logic [7:0] g, input logic [7:0] r);
      logic [7:0] res;
      begin
         unique case (sel)
            yuvrgb_pkg::SEL_BLUE:  res = b;
            yuvrgb_pkg::SEL_GREEN: res = g;
            yuvrgb_pkg::SEL_RED:   res = r;
            default:               res = 8'd0;
         endcase
         pick = res;
      end
   endfunction

   assign rsp_in.out_slot0 = pick(sel0_ff, blue, green, red);
   assign rsp_in.out_slot1 = pick(sel1_ff, blue, green, red);
   assign rsp_in.out_slot2 = pick(sel2_ff, blue, green, red);

   assign rsp_valid = s4_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= 1'b0;
         sel0_ff     <= yuvrgb_pkg::SEL_BLUE;
         sel1_ff     <= yuvrgb_pkg::SEL_GREEN;
         sel2_ff     <= yuvrgb_pkg::SEL_RED;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         sel0_ff <= sel0_in;
         sel1_ff <= sel1_in;
         sel2_ff <= sel2_in;
         if (s1_free) begin
            s1_valid_ff <= s1_valid_in;
         end
         if (s2_free) begin
            s2_valid_ff <= s2_valid_in;
         end
         if (s3_free) begin
            s3_valid_ff <= s3_valid_in;
         end
         if (s4_free) begin
            s4_valid_ff <= s4_valid_in;
         end
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      if (s1_free && req_valid) begin
         in_ff <= in_in;
      end
      if (s2_free && s1_valid_ff) begin
         ys_p_ff <= ys_p_in;
         rv_p_ff <= rv_p_in;
         gv_p_ff <= gv_p_in;
         gu_p_ff <= gu_p_in;
         bu_p_ff <= bu_p_in;
         ys_b_ff <= ys_b_in;
         rv_b_ff <= rv_b_in;
         gv_b_ff <= gv_b_in;
         gu_b_ff <= gu_b_in;
         bu_b_ff <= bu_b_in;
      end
      if (s3_free && s2_valid_ff) begin
         r_p_ff   <= r_p_in;
         g_p_ff   <= g_p_in;
         b_p_ff   <= b_p_in;
         r_b_ff   <= r_b_in;
         g1_b_ff  <= g1_b_in;
         gu3_b_ff <= gu3_b_in;
         b_b_ff   <= b_b_in;
      end
      if (s4_free && s3_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   // ---------------- assertions ----------------
   // a full pipe behind a stalled result pushes back on the input
   assert property (@(posedge clock) disable iff (reset)
      (s4_valid_ff && rsp_stall && s3_valid_ff && s2_valid_ff && s1_valid_ff)
         |-> req_stall)
      else $error("input taken while pipe full and output stalled");

   // an item held in the input register keeps its payload until it moves on
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_free) |=> (s1_valid_ff && $stable(in_ff)))
      else $error("input register item lost or changed while blocked");

   // the result stage empties after a handoff when no item is behind it
   assert property (@(posedge clock) disable iff (reset)
      (s4_valid_ff && !s3_valid_ff && !rsp_stall) |=> !s4_valid_ff)
      else $error("delivered item repeated on output");

endmodule

`default_nettype wire
